>>> hdl/random_code_assigner_assert.svh
// Assertion macros for the code assigner, clocked on clk_i and reset on rst_ni
`ifndef RANDOM_CODE_ASSIGNER_ASSERT_SVH
`define RANDOM_CODE_ASSIGNER_ASSERT_SVH

// same-cycle implication
`define RCA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RCA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/rca_pkg.sv
// Package of widths and constants for the random code assigner
package rca_pkg;

  localparam int unsigned POOL_SIZE_DEF = 256;
  localparam int unsigned NCODES_W      = 9;
  localparam int unsigned RANDOM_W      = 31;
  localparam int unsigned DROP_BITS     = 8;
  localparam int unsigned DIVIDEND_W    = RANDOM_W - DROP_BITS;
  localparam int unsigned DIV_CNT_W     = $clog2(DIVIDEND_W);
  localparam int unsigned CODE_W        = 8;
  localparam int unsigned EPOCH_W       = 8;

  localparam logic [NCODES_W-1:0] NCODES_RST = NCODES_W'(256);
  localparam logic [EPOCH_W-1:0]  EPOCH_LAST = '1;

endpackage

>>> hdl/random_code_assigner.sv
// Random code assigner: draws distinct codes from a pool by a top-down shuffle
//
//   channel | direction | beat holds
//   --------+-----------+-------------------------------------
//   cfg     | in        | number_of_codes
//   in      | in        | start_run, random_word
//   out     | out       | code, exhausted
//
// A draw runs through accept, 23 remainder steps (one bit each), two pool
// reads, one pool write and result load; with no code left, from accept
// to result load. After reset a pass clears all POOL_SIZE pool tags; it
// runs again before a start beat every 255 runs, when the epoch tag wraps.
// A waiting result stalls only the load of the next result, not its accept.
module random_code_assigner #(
  parameter int unsigned POOL_SIZE = rca_pkg::POOL_SIZE_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rca_pkg::NCODES_W-1:0]  number_of_codes_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          start_run_i,
  input  logic [rca_pkg::RANDOM_W-1:0]  random_word_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rca_pkg::CODE_W-1:0]    code_o,
  output logic                          exhausted_o
);
  import rca_pkg::*;

  localparam int unsigned IDX_W   = $clog2(POOL_SIZE);
  localparam int unsigned CNT_W   = $clog2(POOL_SIZE + 1);
  localparam int unsigned ENTRY_W = EPOCH_W + IDX_W;

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_RDS  = 3'd3;
  localparam logic [2:0] ST_RDT  = 3'd4;
  localparam logic [2:0] ST_WR   = 3'd5;
  localparam logic [2:0] ST_OUT  = 3'd6;

  logic [2:0]            state_q, state_d;
  logic [EPOCH_W-1:0]    epoch_q, epoch_d;
  logic [IDX_W-1:0]      clr_q, clr_d;
  logic [NCODES_W-1:0]   ncodes_q;
  logic [CNT_W-1:0]      remaining_q, remaining_d;
  logic [DIVIDEND_W-1:0] dvd_q, dvd_d;
  logic [CNT_W-1:0]      rem_q, rem_d;
  logic [CNT_W-1:0]      div_q, div_d;
  logic [DIV_CNT_W-1:0]  bit_q, bit_d;
  logic [IDX_W-1:0]      drawn_q, drawn_d;
  logic                  exh_q, exh_d;
  logic                  out_valid_q, out_valid_d;
  logic [CODE_W-1:0]     code_q, code_d;
  logic                  exhausted_q, exhausted_d;

  logic [ENTRY_W-1:0]    mem [POOL_SIZE];
  logic [ENTRY_W-1:0]    rd_q;
  logic [IDX_W-1:0]      rd_idx_q;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_wa;
  logic [ENTRY_W-1:0]    mem_wd;
  logic [IDX_W-1:0]      mem_ra;

  logic [IDX_W-1:0]      rd_val;
  logic [CNT_W-1:0]      start_cnt;
  logic [CNT_W-1:0]      draw_cnt;
  logic [CNT_W-1:0]      top_full;
  logic [IDX_W-1:0]      slot;
  logic [IDX_W-1:0]      top;
  logic [CNT_W:0]        trial;
  logic                  wrap_needed;

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign code_o      = code_q;
  assign exhausted_o = exhausted_q;

  assign wrap_needed = start_run_i && (epoch_q == EPOCH_LAST);
  assign in_ready_o  = (state_q == ST_IDLE) && !wrap_needed;

  assign slot     = rem_q[IDX_W-1:0];
  assign top_full = div_q - CNT_W'(1);
  assign top      = top_full[IDX_W-1:0];
  assign trial    = {rem_q, dvd_q[DIVIDEND_W-1]};
  assign draw_cnt = start_run_i ? start_cnt : remaining_q;

  // an entry not written in this run still holds its own index
  assign rd_val = (rd_q[ENTRY_W-1 -: EPOCH_W] == epoch_q) ? rd_q[IDX_W-1:0] : rd_idx_q;

  always_comb begin
    if (32'(ncodes_q) > 32'(POOL_SIZE)) begin
      start_cnt = CNT_W'(POOL_SIZE);
    end else begin
      start_cnt = CNT_W'(ncodes_q);
    end
  end

  always_comb begin
    state_d     = state_q;
    epoch_d     = epoch_q;
    clr_d       = clr_q;
    remaining_d = remaining_q;
    dvd_d       = dvd_q;
    rem_d       = rem_q;
    div_d       = div_q;
    bit_d       = bit_q;
    drawn_d     = drawn_q;
    exh_d       = exh_q;
    out_valid_d = out_valid_q;
    code_d      = code_q;
    exhausted_d = exhausted_q;
    mem_we      = 1'b0;
    mem_wa      = slot;
    mem_wd      = {epoch_q, rd_val};
    mem_ra      = slot;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLR: begin
        mem_we = 1'b1;
        mem_wa = clr_q;
        mem_wd = '0;
        clr_d  = IDX_W'(clr_q + 1'b1);
        if (clr_q == IDX_W'(POOL_SIZE - 1)) begin
          clr_d   = '0;
          epoch_d = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i && wrap_needed) begin
          state_d = ST_CLR;
        end else if (in_valid_i) begin
          if (start_run_i) begin
            epoch_d     = EPOCH_W'(epoch_q + 1'b1);
            remaining_d = start_cnt;
          end
          if (draw_cnt == '0) begin
            exh_d   = 1'b1;
            drawn_d = '0;
            state_d = ST_OUT;
          end else begin
            exh_d   = 1'b0;
            div_d   = draw_cnt;
            rem_d   = '0;
            dvd_d   = random_word_i[RANDOM_W-1:DROP_BITS];
            bit_d   = '0;
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (trial >= {1'b0, div_q}) begin
          rem_d = CNT_W'(trial - {1'b0, div_q});
        end else begin
          rem_d = trial[CNT_W-1:0];
        end
        dvd_d = {dvd_q[DIVIDEND_W-2:0], 1'b0};
        bit_d = DIV_CNT_W'(bit_q + 1'b1);
        if (bit_q == DIV_CNT_W'(DIVIDEND_W - 1)) begin
          state_d = ST_RDS;
        end
      end
      ST_RDS: begin
        mem_ra      = slot;
        remaining_d = top_full;
        state_d     = ST_RDT;
      end
      ST_RDT: begin
        mem_ra  = top;
        drawn_d = rd_val;
        state_d = ST_WR;
      end
      ST_WR: begin
        // top entry is dead for the rest of the run: move it into the slot only
        mem_we  = 1'b1;
        mem_wa  = slot;
        mem_wd  = {epoch_q, rd_val};
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          code_d      = CODE_W'(drawn_q);
          exhausted_d = exh_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      epoch_q     <= '0;
      clr_q       <= '0;
      ncodes_q    <= NCODES_RST;
      remaining_q <= '0;
      exh_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      epoch_q     <= epoch_d;
      clr_q       <= clr_d;
      remaining_q <= remaining_d;
      exh_q       <= exh_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        ncodes_q <= number_of_codes_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q       <= dvd_d;
    rem_q       <= rem_d;
    div_q       <= div_d;
    bit_q       <= bit_d;
    drawn_q     <= drawn_d;
    code_q      <= code_d;
    exhausted_q <= exhausted_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_q     <= mem[mem_ra];
    rd_idx_q <= mem_ra;
  end

`include "random_code_assigner_assert.svh"

  `RCA_ASSERT_NOW(a_exh_code_zero, out_valid_o && exhausted_o, code_o == '0, "exhausted beat carries a code")
  `RCA_ASSERT_NOW(a_remaining_bound, 1'b1, remaining_q <= CNT_W'(POOL_SIZE), "remaining above pool size")
  `RCA_ASSERT_NOW(a_slot_below_top, state_q == ST_WR, slot <= top, "slot above top of pool")
  `RCA_ASSERT_NEXT(a_one_at_a_time, in_valid_i && in_ready_o, !in_ready_o, "second beat taken mid-draw")

endmodule
